// File: sv/spcp_pkg.sv
// Package with the widths, mode codes and pipeline record types of the closest-points unit.
`default_nettype none
package spcp_pkg;

  localparam int COORD_W = 16;            // Q8.8 coordinate
  localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
  localparam int PROD_W  = 2 * DIFF_W;    // product of two differences
  localparam int LEN_W   = 2 * COORD_W + 1;  // squared length, unsigned
  localparam int DOT_W   = 2 * COORD_W + 2;  // dot or cross product, signed
  localparam int NUM_W   = DOT_W + 2;     // numerator before clamping
  localparam int Q_W     = 17;            // Q0.16 fraction including the value one
  localparam int Q_FRAC  = 16;
  localparam int TN_W    = 52;            // scaled numerator of t
  localparam int DIV_MW  = DOT_W;         // divider denominator width
  localparam int DIV_NW  = DIV_MW + Q_FRAC;  // divider dividend width
  localparam int DIV_RW  = DIV_NW + 2;    // partial remainder width
  localparam int DIV_LAT = Q_W;           // one quotient bit per stage
  localparam int DIST_W  = 2 * COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int IN_W    = 8 * COORD_W;
  localparam int OUT_W   = 104;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_BOTH = 2'd0;     // both segments are points
  localparam mode_t MODE_PT1  = 2'd1;     // only the first segment is a point
  localparam mode_t MODE_PT2  = 2'd2;     // only the second segment is a point
  localparam mode_t MODE_GEN  = 2'd3;     // two proper segments

  typedef struct packed {
    logic signed [COORD_W-1:0] p1x;
    logic signed [COORD_W-1:0] p1y;
    logic signed [COORD_W-1:0] p2x;
    logic signed [COORD_W-1:0] p2y;
    logic signed [DIFF_W-1:0]  d1x;
    logic signed [DIFF_W-1:0]  d1y;
    logic signed [DIFF_W-1:0]  d2x;
    logic signed [DIFF_W-1:0]  d2y;
  } geo_t;

  typedef struct packed {
    geo_t                    g;
    mode_t                   mode;
    logic [LEN_W-1:0]        a;
    logic [LEN_W-1:0]        e;
    logic signed [DOT_W-1:0] b;
    logic signed [DOT_W-1:0] c;
    logic signed [DOT_W-1:0] f;
  } ctx1_t;

  typedef struct packed {
    geo_t             g;
    mode_t            mode;
    logic [Q_W-1:0]   q1;
    logic             tneg;
    logic             tbig;
  } ctx2_t;

endpackage
`default_nettype wire

// File: sv/segment_pair_closest_points_unit.sv
// Top level of the closest-points unit for pairs of 2D segments.
//
// The input channel (in_*) carries one transaction per segment pair: eight signed
// Q8.8 endpoint coordinates. The output channel (out_*) returns one transaction per
// pair, in order: the squared distance in Q16.16 and the closest point on each
// segment in Q8.8. The cfg_* port writes the degenerate-length limit; a write takes
// effect at the clock edge where cfg_wen is high and should only be made while the
// unit is empty.
//
// The unit is a 49-stage pipeline, and a new pair can be accepted every cycle while the
// receiver does not hold out_tready low. The length is set by the two chained 17-stage
// fraction dividers (one for the first segment parameter, one for the recomputed
// parameter) plus the product, sum and point-reconstruction stages around them.
//
// Synchronous active-low reset empties the pipeline and sets the limit to one.
// When the receiver holds out_tready low with a result waiting, the whole pipeline
// freezes and in_tready falls; no transaction is dropped or repeated, and flow
// resumes in the cycle out_tready returns.
`default_nettype none
module segment_pair_closest_points_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // From bit 0 up: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y.
  input  wire logic [spcp_pkg::IN_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // From bit 0 up: squared_distance (33), near_first_x, near_first_y,
  // near_second_x, near_second_y, then seven zero bits.
  output logic      [spcp_pkg::OUT_W-1:0]    out_tdata,
  input  wire logic                          cfg_wen,
  input  wire logic [15:0]                   cfg_wdata
);
  import spcp_pkg::*;

  logic        adv;
  logic [15:0] lim_r;

  // Valid bits of every stage.
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [DIV_LAT-1:0] dv1_r;
  logic               v6_r, v7_r, v8_r, v9_r;
  logic [DIV_LAT-1:0] dv2_r;
  logic               v10_r, v11_r, v12_r, v13_r, v14_r;
  logic               out_tvalid_r;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv        = !out_tvalid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 16'd1;
    end else if (cfg_wen) begin
      lim_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      dv1_r <= '0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
      dv2_r <= '0;
      v10_r <= 1'b0; v11_r <= 1'b0; v12_r <= 1'b0; v13_r <= 1'b0; v14_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_tvalid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      dv1_r <= {dv1_r[DIV_LAT-2:0], v5_r};
      v6_r  <= dv1_r[DIV_LAT-1];
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      dv2_r <= {dv2_r[DIV_LAT-2:0], v9_r};
      v10_r <= dv2_r[DIV_LAT-1];
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= v12_r;
      v14_r <= v13_r;
      out_tvalid_r <= v14_r;
    end
  end

  // Stage 1: unpack and form the direction and offset vectors.
  geo_t                     g1_r;
  logic signed [DIFF_W-1:0] rx1_r, ry1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r.p1x <= $signed(in_tdata[15:0]);
      g1_r.p1y <= $signed(in_tdata[31:16]);
      g1_r.p2x <= $signed(in_tdata[79:64]);
      g1_r.p2y <= $signed(in_tdata[95:80]);
      g1_r.d1x <= DIFF_W'($signed(in_tdata[47:32])) - DIFF_W'($signed(in_tdata[15:0]));
      g1_r.d1y <= DIFF_W'($signed(in_tdata[63:48])) - DIFF_W'($signed(in_tdata[31:16]));
      g1_r.d2x <= DIFF_W'($signed(in_tdata[111:96])) - DIFF_W'($signed(in_tdata[79:64]));
      g1_r.d2y <= DIFF_W'($signed(in_tdata[127:112])) - DIFF_W'($signed(in_tdata[95:80]));
      rx1_r    <= DIFF_W'($signed(in_tdata[15:0])) - DIFF_W'($signed(in_tdata[79:64]));
      ry1_r    <= DIFF_W'($signed(in_tdata[31:16])) - DIFF_W'($signed(in_tdata[95:80]));
    end
  end

  // Stage 2: the pairwise products of the vector components that the dot and cross products need.
  geo_t                     g2_r;
  logic signed [PROD_W-1:0] aa1_r, aa2_r, ee1_r, ee2_r, ff1_r, ff2_r, cc1_r, cc2_r;
  logic signed [PROD_W-1:0] bb1_r, bb2_r, cr1_r, cr2_r, ns1_r, ns2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_r  <= g1_r;
      aa1_r <= PROD_W'(g1_r.d1x) * PROD_W'(g1_r.d1x);
      aa2_r <= PROD_W'(g1_r.d1y) * PROD_W'(g1_r.d1y);
      ee1_r <= PROD_W'(g1_r.d2x) * PROD_W'(g1_r.d2x);
      ee2_r <= PROD_W'(g1_r.d2y) * PROD_W'(g1_r.d2y);
      ff1_r <= PROD_W'(g1_r.d2x) * PROD_W'(rx1_r);
      ff2_r <= PROD_W'(g1_r.d2y) * PROD_W'(ry1_r);
      cc1_r <= PROD_W'(g1_r.d1x) * PROD_W'(rx1_r);
      cc2_r <= PROD_W'(g1_r.d1y) * PROD_W'(ry1_r);
      bb1_r <= PROD_W'(g1_r.d1x) * PROD_W'(g1_r.d2x);
      bb2_r <= PROD_W'(g1_r.d1y) * PROD_W'(g1_r.d2y);
      cr1_r <= PROD_W'(g1_r.d1x) * PROD_W'(g1_r.d2y);
      cr2_r <= PROD_W'(g1_r.d1y) * PROD_W'(g1_r.d2x);
      ns1_r <= PROD_W'(g1_r.d2x) * PROD_W'(ry1_r);
      ns2_r <= PROD_W'(g1_r.d2y) * PROD_W'(rx1_r);
    end
  end

  // Stage 3: dot and cross products, and which segments collapse to points.
  ctx1_t                   c3_r;
  logic signed [DOT_W-1:0] cr3_r, ns3_r;
  logic [LEN_W-1:0]        a3_nxt, e3_nxt;
  logic                    pt1_nxt, pt2_nxt;
  mode_t                   mode3_nxt;

  always_comb begin
    a3_nxt  = LEN_W'(aa1_r) + LEN_W'(aa2_r);
    e3_nxt  = LEN_W'(ee1_r) + LEN_W'(ee2_r);
    pt1_nxt = a3_nxt <= LEN_W'(lim_r);
    pt2_nxt = e3_nxt <= LEN_W'(lim_r);
    if (pt1_nxt && pt2_nxt) begin
      mode3_nxt = MODE_BOTH;
    end else if (pt1_nxt) begin
      mode3_nxt = MODE_PT1;
    end else if (pt2_nxt) begin
      mode3_nxt = MODE_PT2;
    end else begin
      mode3_nxt = MODE_GEN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r.g    <= g2_r;
      c3_r.mode <= mode3_nxt;
      c3_r.a    <= a3_nxt;
      c3_r.e    <= e3_nxt;
      c3_r.b    <= DOT_W'(bb1_r) + DOT_W'(bb2_r);
      c3_r.c    <= DOT_W'(cc1_r) + DOT_W'(cc2_r);
      c3_r.f    <= DOT_W'(ff1_r) + DOT_W'(ff2_r);
      cr3_r     <= DOT_W'(cr1_r) - DOT_W'(cr2_r);
      ns3_r     <= DOT_W'(ns1_r) - DOT_W'(ns2_r);
    end
  end

  // Stage 4: pick the first fraction and make its denominator positive.
  ctx1_t                     c4_r;
  logic signed [NUM_W-1:0]   n4_r;
  logic [DIV_MW-1:0]         m4_r;
  logic signed [NUM_W-1:0]   nsel_nxt;
  logic signed [DOT_W:0]     msel_nxt;

  always_comb begin
    case (c3_r.mode)
      MODE_PT1: begin
        nsel_nxt = NUM_W'(c3_r.f);
        msel_nxt = $signed((DOT_W + 1)'(c3_r.e));
      end
      MODE_PT2: begin
        nsel_nxt = -NUM_W'(c3_r.c);
        msel_nxt = $signed((DOT_W + 1)'(c3_r.a));
      end
      MODE_GEN: begin
        if (cr3_r != '0) begin
          nsel_nxt = NUM_W'(ns3_r);
          msel_nxt = (DOT_W + 1)'(cr3_r);
        end else begin
          nsel_nxt = '0;
          msel_nxt = (DOT_W + 1)'(1);
        end
      end
      default: begin
        nsel_nxt = '0;
        msel_nxt = (DOT_W + 1)'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c4_r <= c3_r;
      if (msel_nxt < 0) begin
        n4_r <= -nsel_nxt;
        m4_r <= DIV_MW'(-msel_nxt);
      end else begin
        n4_r <= nsel_nxt;
        m4_r <= DIV_MW'(msel_nxt);
      end
    end
  end

  // Stage 5: clamp the fraction to [0, 1] by clamping the dividend.
  ctx1_t             c5_r;
  logic [DIV_NW-1:0] dn5_r;
  logic [DIV_MW-1:0] dm5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c5_r  <= c4_r;
      dm5_r <= m4_r;
      if (n4_r <= 0) begin
        dn5_r <= '0;
      end else if (n4_r >= $signed(NUM_W'(m4_r))) begin
        dn5_r <= {m4_r, {Q_FRAC{1'b0}}};
      end else begin
        dn5_r <= {n4_r[DIV_MW-1:0], {Q_FRAC{1'b0}}};
      end
    end
  end

  // First divider, with the item's context travelling beside it.
  logic [Q_W-1:0] q1;
  ctx1_t          dl1_r [DIV_LAT];

  spcp_div u_div1 (
    .clk (clk),
    .en  (adv),
    .num (dn5_r),
    .den (dm5_r),
    .quo (q1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl1_r[0] <= c5_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl1_r[i] <= dl1_r[i-1];
      end
    end
  end

  // Stage 6: partial products of b times the quantized s.
  ctx1_t                     c6_r;
  logic [Q_W-1:0]            q6_r;
  logic [Q_W+17:0]           pl6_r;
  logic signed [PROD_W-1:0]  ph6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c6_r  <= dl1_r[DIV_LAT-1];
      q6_r  <= q1;
      pl6_r <= (Q_W + 18)'(dl1_r[DIV_LAT-1].b[17:0]) * (Q_W + 18)'(q1);
      ph6_r <= PROD_W'($signed(dl1_r[DIV_LAT-1].b[DOT_W-1:18]))
             * PROD_W'($signed({1'b0, q1}));
    end
  end

  // Stage 7: scaled numerator of t.
  ctx1_t                   c7_r;
  logic [Q_W-1:0]          q7_r;
  logic signed [TN_W-1:0]  tn7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c7_r  <= c6_r;
      q7_r  <= q6_r;
      tn7_r <= (TN_W'(ph6_r) <<< 18) + $signed(TN_W'(pl6_r))
             + (TN_W'(c6_r.f) <<< Q_FRAC);
    end
  end

  // Stage 8: decide whether t clamps, and pick the second division.
  ctx2_t                   c8_r;
  logic signed [TN_W-1:0]  n8_r;
  logic [DIV_MW-1:0]       m8_r;
  logic                    raw8_r;
  logic                    tneg_nxt, tbig_nxt;

  always_comb begin
    tneg_nxt = tn7_r < 0;
    tbig_nxt = tn7_r > $signed(TN_W'({c7_r.e, {Q_FRAC{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c8_r.g    <= c7_r.g;
      c8_r.mode <= c7_r.mode;
      c8_r.q1   <= q7_r;
      c8_r.tneg <= tneg_nxt;
      c8_r.tbig <= tbig_nxt;
      if (c7_r.mode == MODE_GEN) begin
        if (tneg_nxt) begin
          n8_r   <= -TN_W'(c7_r.c);
          m8_r   <= DIV_MW'(c7_r.a);
          raw8_r <= 1'b0;
        end else if (tbig_nxt) begin
          n8_r   <= TN_W'(c7_r.b) - TN_W'(c7_r.c);
          m8_r   <= DIV_MW'(c7_r.a);
          raw8_r <= 1'b0;
        end else begin
          n8_r   <= tn7_r;
          m8_r   <= DIV_MW'(c7_r.e);
          raw8_r <= 1'b1;
        end
      end else begin
        n8_r   <= '0;
        m8_r   <= DIV_MW'(1);
        raw8_r <= 1'b0;
      end
    end
  end

  // Stage 9: clamp the recomputed s, or pass the t numerator straight on.
  ctx2_t             c9_r;
  logic [DIV_NW-1:0] dn9_r;
  logic [DIV_MW-1:0] dm9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c9_r  <= c8_r;
      dm9_r <= m8_r;
      if (raw8_r) begin
        dn9_r <= n8_r[DIV_NW-1:0];
      end else if (n8_r <= 0) begin
        dn9_r <= '0;
      end else if (n8_r >= $signed(TN_W'(m8_r))) begin
        dn9_r <= {m8_r, {Q_FRAC{1'b0}}};
      end else begin
        dn9_r <= {n8_r[DIV_MW-1:0], {Q_FRAC{1'b0}}};
      end
    end
  end

  // Second divider.
  logic [Q_W-1:0] q2;
  ctx2_t          dl2_r [DIV_LAT];

  spcp_div u_div2 (
    .clk (clk),
    .en  (adv),
    .num (dn9_r),
    .den (dm9_r),
    .quo (q2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2_r[0] <= c9_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl2_r[i] <= dl2_r[i-1];
      end
    end
  end

  // Stage 10: final segment parameters.
  ctx2_t          cq;
  geo_t           g10_r;
  logic [Q_W-1:0] s10_r, t10_r;
  logic [Q_W-1:0] s_nxt, t_nxt;

  assign cq = dl2_r[DIV_LAT-1];

  always_comb begin
    case (cq.mode)
      MODE_PT1: begin
        s_nxt = '0;
        t_nxt = cq.q1;
      end
      MODE_PT2: begin
        s_nxt = cq.q1;
        t_nxt = '0;
      end
      MODE_GEN: begin
        if (cq.tneg) begin
          s_nxt = q2;
          t_nxt = '0;
        end else if (cq.tbig) begin
          s_nxt = q2;
          t_nxt = Q_W'(1) << Q_FRAC;
        end else begin
          s_nxt = cq.q1;
          t_nxt = q2;
        end
      end
      default: begin
        s_nxt = '0;
        t_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g10_r <= cq.g;
      s10_r <= s_nxt;
      t10_r <= t_nxt;
    end
  end

  // Stage 11: direction times parameter.
  geo_t                     g11_r;
  logic signed [PROD_W-1:0] px1_r, py1_r, px2_r, py2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g11_r <= g10_r;
      px1_r <= PROD_W'(g10_r.d1x) * PROD_W'($signed({1'b0, s10_r}));
      py1_r <= PROD_W'(g10_r.d1y) * PROD_W'($signed({1'b0, s10_r}));
      px2_r <= PROD_W'(g10_r.d2x) * PROD_W'($signed({1'b0, t10_r}));
      py2_r <= PROD_W'(g10_r.d2y) * PROD_W'($signed({1'b0, t10_r}));
    end
  end

  // Stage 12: closest points, rounding half toward plus infinity.
  logic signed [COORD_W-1:0] n1x12_r, n1y12_r, n2x12_r, n2y12_r;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (Q_FRAC - 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      n1x12_r <= COORD_W'((DIFF_W + 1)'(g11_r.p1x) + (DIFF_W + 1)'((px1_r + HALF) >>> Q_FRAC));
      n1y12_r <= COORD_W'((DIFF_W + 1)'(g11_r.p1y) + (DIFF_W + 1)'((py1_r + HALF) >>> Q_FRAC));
      n2x12_r <= COORD_W'((DIFF_W + 1)'(g11_r.p2x) + (DIFF_W + 1)'((px2_r + HALF) >>> Q_FRAC));
      n2y12_r <= COORD_W'((DIFF_W + 1)'(g11_r.p2y) + (DIFF_W + 1)'((py2_r + HALF) >>> Q_FRAC));
    end
  end

  // Stage 13: separation vector.
  logic signed [COORD_W-1:0] n1x13_r, n1y13_r, n2x13_r, n2y13_r;
  logic signed [DIFF_W-1:0]  dx13_r, dy13_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n1x13_r <= n1x12_r;
      n1y13_r <= n1y12_r;
      n2x13_r <= n2x12_r;
      n2y13_r <= n2y12_r;
      dx13_r  <= DIFF_W'(n1x12_r) - DIFF_W'(n2x12_r);
      dy13_r  <= DIFF_W'(n1y12_r) - DIFF_W'(n2y12_r);
    end
  end

  // Stage 14: squares.
  logic signed [COORD_W-1:0] n1x14_r, n1y14_r, n2x14_r, n2y14_r;
  logic [SQ_W-1:0]           sqx14_r, sqy14_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n1x14_r <= n1x13_r;
      n1y14_r <= n1y13_r;
      n2x14_r <= n2x13_r;
      n2y14_r <= n2y13_r;
      sqx14_r <= SQ_W'(PROD_W'(dx13_r) * PROD_W'(dx13_r));
      sqy14_r <= SQ_W'(PROD_W'(dy13_r) * PROD_W'(dy13_r));
    end
  end

  // Output register: squared distance and packing.
  logic [OUT_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {7'd0, n2y14_r, n2x14_r, n1y14_r, n1x14_r,
                      DIST_W'(sqx14_r) + DIST_W'(sqy14_r)};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule
`default_nettype wire

// File: sv/spcp_div.sv
// Pipelined restoring divider giving round(num / den) as a Q0.16 fraction, one bit per stage.
`default_nettype none
module spcp_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [spcp_pkg::DIV_NW-1:0]  num,
  input  wire logic [spcp_pkg::DIV_MW-1:0]  den,
  output logic      [spcp_pkg::Q_W-1:0]     quo
);
  import spcp_pkg::*;

  logic [DIV_RW-1:0] rem_r [DIV_LAT];
  logic [DIV_MW:0]   dd_r  [DIV_LAT];
  logic [Q_W-1:0]    q_r   [DIV_LAT];

  // Rounding is folded in: the quotient of (2*num + den) by 2*den, halves up.
  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    logic [DIV_RW-1:0] rem_in;
    logic [DIV_RW-1:0] sub;
    logic [DIV_MW:0]   dd_in;
    logic [Q_W-1:0]    q_in;
    logic              take;

    if (i == 0) begin : g_first
      assign rem_in = {1'b0, num, 1'b0} + DIV_RW'(den);
      assign dd_in  = {den, 1'b0};
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dd_in  = dd_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign sub  = DIV_RW'(dd_in) << (DIV_LAT - 1 - i);
    assign take = rem_in >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? rem_in - sub : rem_in;
        dd_r[i]  <= dd_in;
        q_r[i]   <= q_in | (Q_W'(take) << (DIV_LAT - 1 - i));
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];

endmodule
`default_nettype wire

// File: tb/sv/segment_pair_closest_points_unit_tb.sv
// Testbench for the segment-pair closest-points unit: directed and random pairs vs. a predictor.
//
// Every segment pair that the unit accepts is run through a behavioral predictor
// in this file. The prediction is pushed onto a queue of pending results. A
// separate monitor pops the oldest prediction for each result transaction and
// compares the five fields. Both channels idle at random, and the limit register
// is rewritten between phases while the pipeline is empty.
`default_nettype none
module segment_pair_closest_points_unit_tb;
  import spcp_pkg::*;

  localparam int PIPE_LAT = 49;
  localparam longint QONE = 64'sd65536;

  typedef struct packed {
    logic signed [15:0] sx1, sy1, ex1, ey1, sx2, sy2, ex2, ey2;
  } pair_t;

  typedef struct packed {
    logic [32:0] sq_dist;
    logic signed [15:0] n1x, n1y, n2x, n2y;
  } closest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // The predictor's own copy of the limit register.
  logic [15:0] point_limit = 16'd1;
  closest_t pending_closest[$];
  int n_mismatch = 0;
  // While set, the receiver keeps out_tready low so the pipeline backs up.
  bit hold_receiver = 1'b0;
  bit sink_busy = 1'b0;

  segment_pair_closest_points_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Q0.16 fraction of n/m, clamped to [0, 1], halves rounded up.
  function automatic longint fraction_q16(longint n, longint m);
    if (m < 0) begin
      n = -n;
      m = -m;
    end
    if (n <= 0) return 0;
    if (n >= m) return QONE;
    return (2 * n * QONE + m) / (2 * m);
  endfunction

  // start + round(d * q / 2^16), halves toward plus infinity.
  function automatic longint point_along(longint start, longint d, longint q);
    longint v;
    v = d * q + QONE / 2;
    return start + (v >>> 16);
  endfunction

  function automatic closest_t predict_closest(pair_t p);
    longint d1x, d1y, d2x, d2y, rx, ry, a, e, f, c, b, cr, tn, s, t;
    longint m1x, m1y, m2x, m2y, dx, dy;
    bit pt1, pt2;
    closest_t r;
    d1x = longint'(p.ex1) - p.sx1;
    d1y = longint'(p.ey1) - p.sy1;
    d2x = longint'(p.ex2) - p.sx2;
    d2y = longint'(p.ey2) - p.sy2;
    rx = longint'(p.sx1) - p.sx2;
    ry = longint'(p.sy1) - p.sy2;
    a = d1x * d1x + d1y * d1y;
    e = d2x * d2x + d2y * d2y;
    f = d2x * rx + d2y * ry;
    c = d1x * rx + d1y * ry;
    pt1 = a <= longint'(point_limit);
    pt2 = e <= longint'(point_limit);
    s = 0;
    t = 0;
    if (pt1 && pt2) begin
      s = 0;
    end else if (pt1) begin
      t = fraction_q16(f, e);
    end else if (pt2) begin
      s = fraction_q16(-c, a);
    end else begin
      b = d1x * d2x + d1y * d2y;
      cr = d1x * d2y - d1y * d2x;
      s = (cr != 0) ? fraction_q16(d2x * ry - d2y * rx, cr) : 0;
      tn = b * s + f * QONE;
      if (tn < 0) begin
        t = 0;
        s = fraction_q16(-c, a);
      end else if (tn > e * QONE) begin
        t = QONE;
        s = fraction_q16(b - c, a);
      end else begin
        t = (2 * tn + e) / (2 * e);
      end
    end
    m1x = point_along(p.sx1, d1x, s);
    m1y = point_along(p.sy1, d1y, s);
    m2x = point_along(p.sx2, d2x, t);
    m2y = point_along(p.sy2, d2y, t);
    dx = m1x - m2x;
    dy = m1y - m2y;
    r.sq_dist = 33'(dx * dx + dy * dy);
    r.n1x = 16'(m1x);
    r.n1y = 16'(m1y);
    r.n2x = 16'(m2x);
    r.n2y = 16'(m2y);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_pair(pair_t p);
    return {p.ey2, p.ex2, p.sy2, p.sx2, p.ey1, p.ex1, p.sy1, p.sx1};
  endfunction

  function automatic int idle_length();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // Sends one pair; the prediction is queued at the edge that accepts it.
  // in_tvalid stays high after the accepting edge so that pairs can follow
  // back to back; a gap or wait_drained() takes it low.
  task automatic send_pair(pair_t p, bit may_idle = 1'b1);
    int gap;
    gap = may_idle ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= pack_pair(p);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_closest.push_back(predict_closest(p));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_closest.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_limit(logic [15:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_wen <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
    point_limit = value;
  endtask

  function automatic pair_t make_pair(logic signed [15:0] v[8]);
    pair_t p;
    p = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    return p;
  endfunction

  // Small coordinates around a common center, so segments interact often.
  function automatic logic signed [15:0] coord_near(int center, int span);
    int v;
    v = center + $urandom_range(0, 2 * span) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic pair_t random_pair();
    logic signed [15:0] v[8];
    int kind, center, span;
    kind = $urandom_range(0, 9);
    center = int'($urandom_range(0, 65535)) - 32768;
    span = 1 << $urandom_range(0, 14);
    for (int i = 0; i < 8; i++) v[i] = coord_near(center, span);
    case (kind)
      0: for (int i = 0; i < 8; i++) v[i] = 16'($urandom);
      1: begin
        // First segment collapses to a point, possibly within the limit.
        v[2] = v[0] + 16'($urandom_range(0, 2));
        v[3] = v[1];
      end
      2: begin
        v[6] = v[4];
        v[7] = v[5] + 16'($urandom_range(0, 2));
      end
      3: begin
        // Parallel pair: the second segment is a shifted copy of the first.
        v[4] = v[0] + 16'($urandom_range(0, 64));
        v[5] = v[1] + 16'($urandom_range(0, 64));
        v[6] = v[4] + (v[2] - v[0]);
        v[7] = v[5] + (v[3] - v[1]);
      end
      4: begin
        // Collinear with a scaled direction, often overlapping.
        v[4] = v[0] - (v[2] - v[0]);
        v[5] = v[1] - (v[3] - v[1]);
        v[6] = v[2];
        v[7] = v[3];
      end
      default: ;
    endcase
    return make_pair(v);
  endfunction

  task automatic test_extremes();
    logic signed [15:0] lo, hi;
    lo = -16'sd32768;
    hi = 16'sd32767;
    send_pair(make_pair('{lo, lo, hi, hi, hi, lo, lo, hi}));
    send_pair(make_pair('{hi, hi, lo, lo, lo, hi, hi, lo}));
    send_pair(make_pair('{lo, lo, lo, lo, hi, hi, hi, hi}));
    send_pair(make_pair('{lo, lo, hi, lo, lo, hi, hi, hi}));
    send_pair(make_pair('{hi, hi, hi, hi, hi, hi, hi, hi}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd5, 16'sd5, 16'sd5, 16'sd5}));
  endtask

  task automatic test_special_cases();
    // Both points, first point only, second point only.
    send_pair(make_pair('{16'sd10, 16'sd10, 16'sd10, 16'sd10,
                          -16'sd5, 16'sd3, -16'sd5, 16'sd3}));
    send_pair(make_pair('{16'sd100, 16'sd50, 16'sd100, 16'sd50,
                          16'sd0, 16'sd0, 16'sd512, 16'sd0}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd512, 16'sd0,
                          16'sd300, -16'sd90, 16'sd300, -16'sd90}));
    // Second point off either end of the first segment.
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd512, 16'sd0,
                          -16'sd900, 16'sd7, -16'sd900, 16'sd7}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd512, 16'sd0,
                          16'sd900, 16'sd7, 16'sd900, 16'sd7}));
    // Parallel segments, crossing segments, and t clamped low and high.
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd256, 16'sd0,
                          16'sd64, 16'sd40, 16'sd320, 16'sd40}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd256, 16'sd0,
                          16'sd0, 16'sd256, 16'sd256, 16'sd256}));
    send_pair(make_pair('{-16'sd256, 16'sd0, 16'sd256, 16'sd0,
                          16'sd0, -16'sd256, 16'sd0, 16'sd256}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd256, 16'sd0,
                          16'sd128, 16'sd50, 16'sd128, 16'sd500}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd256, 16'sd0,
                          16'sd128, -16'sd500, 16'sd128, -16'sd50}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd256, 16'sd256,
                          16'sd900, 16'sd0, 16'sd1200, 16'sd100}));
    send_pair(make_pair('{16'sd0, 16'sd0, 16'sd3, 16'sd7,
                          16'sd11, -16'sd2, 16'sd1, 16'sd5}));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering pairs.
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    fork
      begin
        for (int i = 0; i < 80; i++) send_pair(random_pair(), 1'b0);
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      begin
        repeat (150) @(negedge clk);
        hold_receiver = 1'b0;
      end
    join
  endtask

  // Receiver side: random tready with long gaps now and then.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_tready <= 1'b0;
      end else if (!sink_busy && $urandom_range(0, 5) == 0) begin
        gap = idle_length();
        out_tready <= 1'b0;
        sink_busy = 1'b1;
        fork
          begin
            repeat (gap) @(negedge clk);
            sink_busy = 1'b0;
          end
        join_none
      end else begin
        out_tready <= !sink_busy;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    closest_t want;
    closest_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.sq_dist = out_tdata[32:0];
      got.n1x = out_tdata[48:33];
      got.n1y = out_tdata[64:49];
      got.n2x = out_tdata[80:65];
      got.n2y = out_tdata[96:81];
      if (pending_closest.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transaction: %h", out_tdata);
      end else begin
        want = pending_closest.pop_front();
        if (want != got) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected dist %0d p1 (%0d,%0d) p2 (%0d,%0d), %s",
                     want.sq_dist, want.n1x, want.n1y, want.n2x, want.n2y,
                     $sformatf("got dist %0d p1 (%0d,%0d) p2 (%0d,%0d)",
                               got.sq_dist, got.n1x, got.n1y, got.n2x, got.n2y));
        end
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_special_cases();
    write_limit(16'd0);
    test_special_cases();
    test_random(300);
    write_limit(16'hFFFF);
    test_special_cases();
    test_random(300);
    write_limit(16'd300);
    test_backpressure();
    // Sender pauses here until the pipeline has fully drained.
    wait_drained();
    test_random(300);
    write_limit(16'($urandom_range(0, 65535)));
    test_random(300);
    write_limit(16'd1);
    test_extremes();
    test_random(100);
    wait_drained();
    if (n_mismatch == 0 && pending_closest.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
